>>> design/icymd_pkg.sv
package icymd_pkg;

    // Fixed field widths.
    localparam int BYTE_WIDTH     = 8;
    localparam int INTERVAL_WIDTH = 20;
    localparam int COUNT_WIDTH    = 20;
    localparam int META_WIDTH     = 12;
    localparam int CMP_WIDTH      = (COUNT_WIDTH > INTERVAL_WIDTH) ? COUNT_WIDTH
                                                                   : INTERVAL_WIDTH;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = INTERVAL_WIDTH;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_META_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYNC_HUNT     = 2'd1;

    // Byte kinds.
    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_META  = 1'b1;

    // Sync pattern.
    localparam logic [BYTE_WIDTH-1:0] SYNC_BYTE   = 8'hff;
    localparam logic [BYTE_WIDTH-1:0] SYNC_NIBBLE = 8'hf0;

    // Result word queue.
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_WIDTH = 2;
    localparam int FIFO_CNT_WIDTH = 3;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data;
        logic                  kind;
        logic                  meta_last;
        logic                  last;
    } result_t;

endpackage

>>> design/icymd_core.sv
module icymd_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  logic [icymd_pkg::BYTE_WIDTH-1:0]     in_byte,
    input  logic [icymd_pkg::INTERVAL_WIDTH-1:0] meta_interval,
    input  logic                                 sync_hunt_enable,
    output logic [1:0]                           res_cnt,
    output icymd_pkg::result_t                   res0,
    output icymd_pkg::result_t                   res1
);
    import icymd_pkg::*;

    logic [COUNT_WIDTH-1:0] audio_count_reg, audio_count_next;
    logic [META_WIDTH-1:0]  meta_rem_reg, meta_rem_next;
    logic                   sync_found_reg, sync_found_next;
    logic                   held_ff_reg, held_ff_next;
    logic                   is_length;
    logic [META_WIDTH-1:0]  block_len;

    // A length byte is due once the audio count has reached the interval.
    assign is_length = (meta_interval != '0) &&
                       (CMP_WIDTH'(audio_count_reg) >= CMP_WIDTH'(meta_interval));
    assign block_len = META_WIDTH'({in_byte, 4'b0000});

    // Classify the current word and work out its results and the next state.
    always_comb begin
        audio_count_next = audio_count_reg;
        meta_rem_next    = meta_rem_reg;
        sync_found_next  = sync_found_reg;
        held_ff_next     = held_ff_reg;
        res_cnt          = 2'd0;
        res0             = '{data: in_byte, kind: KIND_AUDIO, meta_last: 1'b0, last: 1'b1};
        res1             = '{data: in_byte, kind: KIND_AUDIO, meta_last: 1'b0, last: 1'b1};

        if (meta_rem_reg != '0) begin
            // Inside a metadata block.
            meta_rem_next = meta_rem_reg - META_WIDTH'(1);
            if (meta_rem_reg == META_WIDTH'(1)) begin
                audio_count_next = '0;
            end
            res_cnt        = 2'd1;
            res0.kind      = KIND_META;
            res0.meta_last = (meta_rem_reg == META_WIDTH'(1));
        end else if (is_length) begin
            // Length byte: consumed, opens a block or restarts counting.
            meta_rem_next = block_len;
            if (block_len == '0) begin
                audio_count_next = '0;
            end
        end else begin
            // Audio byte, counted even when the hunt drops it.
            if (audio_count_reg != '1) begin
                audio_count_next = audio_count_reg + COUNT_WIDTH'(1);
            end
            if (!sync_hunt_enable || sync_found_reg) begin
                held_ff_next = 1'b0;
                res_cnt      = 2'd1;
            end else if (held_ff_reg && ((in_byte & SYNC_NIBBLE) == SYNC_NIBBLE)) begin
                // Sync pair complete: release the held 0xFF, then this byte.
                sync_found_next = 1'b1;
                held_ff_next    = 1'b0;
                res_cnt         = 2'd2;
                res0.data       = SYNC_BYTE;
                res0.last       = 1'b0;
            end else begin
                held_ff_next = (in_byte == SYNC_BYTE);
            end
        end
    end

    // Stream state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_count_reg <= '0;
            meta_rem_reg    <= '0;
            sync_found_reg  <= 1'b0;
            held_ff_reg     <= 1'b0;
        end else if (step) begin
            audio_count_reg <= audio_count_next;
            meta_rem_reg    <= meta_rem_next;
            sync_found_reg  <= sync_found_next;
            held_ff_reg     <= held_ff_next;
        end
    end

endmodule

>>> design/icymd_result_fifo.sv
module icymd_result_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  icymd_pkg::result_t push0,
    input  icymd_pkg::result_t push1,
    output logic               room2,
    output logic               out_valid,
    input  logic               out_ready,
    output icymd_pkg::result_t out_word
);
    import icymd_pkg::*;

    result_t                   mem [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_WIDTH-1:0] count_reg, count_next;
    logic                      pop;

    // Room for two words is judged on the registered fill level.
    assign room2     = (count_reg <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_WIDTH'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_WIDTH'(pop);
        count_next  = count_reg + FIFO_CNT_WIDTH'(push_cnt) - FIFO_CNT_WIDTH'(pop);
    end

    // Storage: up to two words are written per cycle.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_WIDTH'(1)] <= push1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/icy_metadata_deinterleaver.sv
// Splits an interleaved stream of audio bytes and metadata blocks, one word per
// cycle. After every meta_interval audio bytes a length byte L is taken out of
// the stream and the following L*16 bytes are passed on tagged as metadata, the
// final one flagged by m_meta_last; a meta_interval of zero passes everything
// as audio. With sync_hunt_enable set, audio is dropped after reset until the
// first 0xFF, 0xFx pair, which comes out as two words (the only input that
// yields two). An input word is registered, decoded combinationally and placed
// in a four-word result queue, so the block takes one word every cycle while
// the output side keeps up; it stalls only when the queue lacks room for two
// words. Configuration writes are meant for idle periods and act on the next
// word.
module icy_metadata_deinterleaver (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [icymd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [icymd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [icymd_pkg::BYTE_WIDTH-1:0]      s_in_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [icymd_pkg::BYTE_WIDTH-1:0]      m_out_byte,
    output logic                                  m_byte_kind,
    output logic                                  m_meta_last,
    output logic                                  m_last
);
    import icymd_pkg::*;

    logic [INTERVAL_WIDTH-1:0] meta_interval_reg;
    logic                      sync_hunt_reg;
    logic                      in_vld_reg;
    logic [BYTE_WIDTH-1:0]     in_byte_reg;
    logic                      room2;
    logic                      step;
    logic [1:0]                res_cnt;
    logic [1:0]                push_cnt;
    result_t                   res0, res1, out_word;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_interval_reg <= '0;
            sync_hunt_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_META_INTERVAL: meta_interval_reg <= cfg_wdata[INTERVAL_WIDTH-1:0];
                REG_SYNC_HUNT:     sync_hunt_reg     <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // Input register: the held word is decoded once the queue has room.
    assign step    = in_vld_reg && room2;
    assign s_ready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    icymd_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .in_byte          (in_byte_reg),
        .meta_interval    (meta_interval_reg),
        .sync_hunt_enable (sync_hunt_reg),
        .res_cnt          (res_cnt),
        .res0             (res0),
        .res1             (res1)
    );

    assign push_cnt = step ? res_cnt : 2'd0;

    icymd_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_out_byte  = out_word.data;
    assign m_byte_kind = out_word.kind;
    assign m_meta_last = out_word.meta_last;
    assign m_last      = out_word.last;

endmodule
